// ===== hdl/vpp_pkg.sv =====
// Shared types and constants for the vertex projection pipeline.
// No dependencies; every other file in the block imports this package.
package vpp_pkg;

   localparam int COORD_W = 32;
   localparam int COEF_REG_W = 64;
   localparam int SCREEN_REG_W = 13;
   localparam int CSR_W = 64;
   localparam int CSR_IDX_W = 3;
   localparam int PROJ_W = 48;
   localparam int SUM_W = 66;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X_XY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X_ZT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y_XY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y_ZT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_W_XY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_W_ZT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_W = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_H = 3'd7;

   // Status that travels with the two quotients into the screen mapper.
   typedef struct packed {
      logic behind;
      logic col_overflow;
      logic row_overflow;
   } vpp_map_status_type;

   // Flags of one finished result.
   typedef struct packed {
      logic behind_camera;
      logic on_screen;
   } vpp_flags_type;

endpackage

// ===== hdl/vpp_column_mac.sv =====
// One column of the transform: three signed products, then floor, sum and saturate.
// Depends on vpp_pkg. Two register stages.
module vpp_column_mac #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [vpp_pkg::COORD_W-1:0] vx,
   input  logic signed [vpp_pkg::COORD_W-1:0] vy,
   input  logic signed [vpp_pkg::COORD_W-1:0] vz,
   input  logic [vpp_pkg::COEF_REG_W-1:0]     coef_xy,
   input  logic [vpp_pkg::COEF_REG_W-1:0]     coef_zt,
   output logic signed [vpp_pkg::PROJ_W-1:0]  sum
);
   import vpp_pkg::*;

   logic signed [63:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [63:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [31:0] trans_ff;
   logic signed [SUM_W-1:0] total;
   logic signed [PROJ_W-1:0] sum_in, sum_ff;

   always_comb begin
      prod_x_in = vx * $signed(coef_xy[31:0]);
      prod_y_in = vy * $signed(coef_xy[63:32]);
      prod_z_in = vz * $signed(coef_zt[31:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         trans_ff  <= $signed(coef_zt[63:32]);
      end
   end

   // Arithmetic shifts floor each product; the sum is then clamped to 48 bits.
   always_comb begin
      total = SUM_W'(prod_x_ff >>> FRAC_BITS) + SUM_W'(prod_y_ff >>> FRAC_BITS)
            + SUM_W'(prod_z_ff >>> FRAC_BITS) + SUM_W'(trans_ff);
      if ((&total[SUM_W-1:PROJ_W-1]) || !(|total[SUM_W-1:PROJ_W-1])) begin
         sum_in = total[PROJ_W-1:0];
      end else if (total[SUM_W-1]) begin
         sum_in = {1'b1, {(PROJ_W-1){1'b0}}};
      end else begin
         sum_in = {1'b0, {(PROJ_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== hdl/vpp_floor_div.sv =====
// Pipelined floor division of a signed numerator by a positive denominator.
// Depends on vpp_pkg. One restoring step per stage; flags quotients out of range.
module vpp_floor_div #(
   parameter int NUM_W = 63,
   parameter int DEN_W = 49,
   parameter int QUO_W = 14
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic signed [QUO_W:0]   quo,
   output logic                    overflow
);
   import vpp_pkg::*;

   logic [NUM_W-1:0] rem_ff [0:QUO_W];
   logic [DEN_W-1:0] den_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic             neg_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];
   logic [NUM_W-1:0] mag_in;

   // For a negative numerator, floor(n/d) = ~floor((-n-1)/d), and -n-1 is ~n.
   assign mag_in = num[NUM_W-1] ? ~num : num;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= mag_in;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         neg_ff[0] <= num[NUM_W-1];
         ovf_ff[0] <= ({1'b0, mag_in} >= ({(NUM_W + 1)'(den)} << QUO_W));
      end
   end

   for (genvar i = 1; i <= QUO_W; i++) begin : g_step
      logic [NUM_W-1:0] trial;
      logic             fits;
      assign trial = NUM_W'(den_ff[i-1]) << (QUO_W - i);
      assign fits  = rem_ff[i-1] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= fits ? rem_ff[i-1] - trial : rem_ff[i-1];
            den_ff[i] <= den_ff[i-1];
            quo_ff[i] <= quo_ff[i-1] | (QUO_W'(fits) << (QUO_W - i));
            neg_ff[i] <= neg_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
         end
      end
   end

   assign quo      = neg_ff[QUO_W] ? ~$signed({1'b0, quo_ff[QUO_W]})
                                   : $signed({1'b0, quo_ff[QUO_W]});
   assign overflow = ovf_ff[QUO_W];

endmodule

// ===== hdl/vpp_pixel_map.sv =====
// Maps the two quotients to a pixel column, row and address, with screen tests.
// Depends on vpp_pkg. Two register stages.
module vpp_pixel_map #(
   parameter int MAX_DIM_BITS = 12
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [MAX_DIM_BITS+2:0]   quo_col,
   input  logic signed [MAX_DIM_BITS+2:0]   quo_row,
   input  vpp_pkg::vpp_map_status_type      status,
   input  logic [MAX_DIM_BITS:0]            dim_w,
   input  logic [MAX_DIM_BITS:0]            dim_h,
   output logic [MAX_DIM_BITS-1:0]          column,
   output logic [MAX_DIM_BITS-1:0]          row,
   output logic [2*MAX_DIM_BITS-1:0]        pixel_address,
   output vpp_pkg::vpp_flags_type           flags
);
   import vpp_pkg::*;

   localparam int DIM_W = MAX_DIM_BITS + 1;
   localparam int POS_W = DIM_W + 3;

   logic signed [POS_W-1:0] col_pos, row_pos;
   logic col_in_range, row_in_range, on_in;
   logic [MAX_DIM_BITS-1:0] col_ff, row_ff;
   logic on_ff, behind_ff;
   logic [MAX_DIM_BITS-1:0] column_ff, row_out_ff;
   logic [2*MAX_DIM_BITS-1:0] addr_ff;
   vpp_flags_type flags_ff;

   always_comb begin
      col_pos = POS_W'(quo_col) + $signed({1'b0, dim_w >> 1});
      row_pos = POS_W'(quo_row) + $signed({1'b0, dim_h >> 1});
      col_in_range = !col_pos[POS_W-1] && (col_pos[POS_W-2:0] < (POS_W-1)'(dim_w));
      row_in_range = !row_pos[POS_W-1] && (row_pos[POS_W-2:0] < (POS_W-1)'(dim_h));
      on_in = !status.behind && !status.col_overflow && !status.row_overflow
            && col_in_range && row_in_range;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff    <= col_pos[MAX_DIM_BITS-1:0];
         row_ff    <= row_pos[MAX_DIM_BITS-1:0];
         on_ff     <= on_in;
         behind_ff <= status.behind;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         column_ff  <= on_ff ? col_ff : '0;
         row_out_ff <= on_ff ? row_ff : '0;
         addr_ff    <= on_ff ? (2*MAX_DIM_BITS)'(row_ff) * (2*MAX_DIM_BITS)'(dim_w)
                               + (2*MAX_DIM_BITS)'(col_ff)
                             : '0;
         flags_ff.on_screen     <= on_ff;
         flags_ff.behind_camera <= behind_ff;
      end
   end

   assign column        = column_ff;
   assign row           = row_out_ff;
   assign pixel_address = addr_ff;
   assign flags         = flags_ff;

endmodule

// ===== hdl/vertex_project_to_pixel.sv =====
// Top level of the vertex projection pipeline: registers, scaling and flow control.
// Depends on vpp_pkg, vpp_column_mac, vpp_floor_div and vpp_pixel_map.
//
//   Channel | Direction | Handshake         | Contents
//   req_    | in        | tvalid / tready   | tdata: vertex_x, vertex_y, vertex_z
//   rsp_    | out       | tvalid / tready   | tdata: column, row, pixel_address;
//           |           |                   | tuser: on_screen, behind_camera
//   csr_    | in        | we, no handshake  | index, wdata
//
// One request enters every cycle unless a result waits on rsp_tready; each result passes
// through MAX_DIM_BITS + 8 register stages, a depth set mostly by the one-bit-per-stage
// quotient pipeline.
// Reset clears the valid bits and returns every configuration register to its default.
// When a result waits on rsp_tready, every stage holds, so nothing is lost or repeated;
// req_tready is low only during that wait.
module vertex_project_to_pixel #(
   parameter int FRAC_BITS    = 16,
   parameter int MAX_DIM_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
   input  logic [3*vpp_pkg::COORD_W-1:0]      req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // column, row, pixel_address from the lowest bit, zero padding to whole bytes
   output logic [((4*MAX_DIM_BITS+7)/8)*8-1:0] rsp_tdata,
   // on_screen [0], behind_camera [1]
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_we,
   input  logic [vpp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vpp_pkg::CSR_W-1:0]          csr_wdata
);
   import vpp_pkg::*;

   localparam int DIM_W = MAX_DIM_BITS + 1;
   localparam int QUO_W = DIM_W + 1;
   localparam int NUM_W = 50 + DIM_W;
   localparam int DEN_W = PROJ_W + 1;
   localparam int RSP_W = ((4*MAX_DIM_BITS+7)/8)*8;
   localparam int LAT = QUO_W + 6;
   localparam int CMP_W = (DIM_W > SCREEN_REG_W) ? DIM_W : SCREEN_REG_W;
   localparam logic [CMP_W-1:0] DIM_LIM = CMP_W'(1) << MAX_DIM_BITS;

   // Configuration registers.
   logic [COEF_REG_W-1:0] coef_ff [0:5];
   logic [SCREEN_REG_W-1:0] scr_w_ff, scr_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= 64'd65536;
         coef_ff[1] <= 64'd0;
         coef_ff[2] <= 64'd281474976710656;
         coef_ff[3] <= 64'd0;
         coef_ff[4] <= 64'd0;
         coef_ff[5] <= 64'd281474976710656;
         scr_w_ff   <= 13'd640;
         scr_h_ff   <= 13'd480;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF_X_XY: coef_ff[0] <= csr_wdata;
            CSR_COEF_X_ZT: coef_ff[1] <= csr_wdata;
            CSR_COEF_Y_XY: coef_ff[2] <= csr_wdata;
            CSR_COEF_Y_ZT: coef_ff[3] <= csr_wdata;
            CSR_COEF_W_XY: coef_ff[4] <= csr_wdata;
            CSR_COEF_W_ZT: coef_ff[5] <= csr_wdata;
            CSR_SCREEN_W:  scr_w_ff   <= csr_wdata[SCREEN_REG_W-1:0];
            CSR_SCREEN_H:  scr_h_ff   <= csr_wdata[SCREEN_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Screen sizes above the supported maximum act as the maximum.
   logic [DIM_W-1:0] dim_w, dim_h;
   always_comb begin
      dim_w = (CMP_W'(scr_w_ff) > DIM_LIM) ? DIM_LIM[DIM_W-1:0] : DIM_W'(scr_w_ff);
      dim_h = (CMP_W'(scr_h_ff) > DIM_LIM) ? DIM_LIM[DIM_W-1:0] : DIM_W'(scr_h_ff);
   end

   // The whole pipeline advances together whenever the output slot is free or taken.
   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic vld_ff [0:LAT-1];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Transform: three columns, two stages each.
   logic signed [COORD_W-1:0] vx, vy, vz;
   logic signed [PROJ_W-1:0] px, py, pw;
   assign vx = $signed(req_tdata[COORD_W-1:0]);
   assign vy = $signed(req_tdata[2*COORD_W-1:COORD_W]);
   assign vz = $signed(req_tdata[3*COORD_W-1:2*COORD_W]);

   vpp_column_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_x (
      .clock(clock), .en(en), .vx(vx), .vy(vy), .vz(vz),
      .coef_xy(coef_ff[0]), .coef_zt(coef_ff[1]), .sum(px));
   vpp_column_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_y (
      .clock(clock), .en(en), .vx(vx), .vy(vy), .vz(vz),
      .coef_xy(coef_ff[2]), .coef_zt(coef_ff[3]), .sum(py));
   vpp_column_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_w (
      .clock(clock), .en(en), .vx(vx), .vy(vy), .vz(vz),
      .coef_xy(coef_ff[4]), .coef_zt(coef_ff[5]), .sum(pw));

   // Scale stage: numerators x*W and -y*H over the common denominator 2w.
   logic signed [NUM_W-1:0] num_x_in, num_y_in, num_x_ff, num_y_ff;
   logic [DEN_W-1:0] den_ff;
   logic beh_ff [0:QUO_W+1];

   always_comb begin
      num_x_in = px * $signed({1'b0, dim_w});
      num_y_in = -(py * $signed({1'b0, dim_h}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_x_ff  <= num_x_in;
         num_y_ff  <= num_y_in;
         den_ff    <= {1'b0, pw[PROJ_W-2:0], 1'b0} & {DEN_W{!pw[PROJ_W-1]}};
         beh_ff[0] <= pw[PROJ_W-1] || (pw == '0);
         for (int i = 1; i <= QUO_W + 1; i++) begin
            beh_ff[i] <= beh_ff[i-1];
         end
      end
   end

   // Quotients, one bit per stage.
   logic signed [QUO_W:0] quo_col, quo_row;
   vpp_map_status_type status;

   vpp_floor_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_col (
      .clock(clock), .en(en), .num(num_x_ff), .den(den_ff),
      .quo(quo_col), .overflow(status.col_overflow));
   vpp_floor_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_row (
      .clock(clock), .en(en), .num(num_y_ff), .den(den_ff),
      .quo(quo_row), .overflow(status.row_overflow));

   assign status.behind = beh_ff[QUO_W+1];

   // Screen mapping and the output register.
   logic [MAX_DIM_BITS-1:0] column, row;
   logic [2*MAX_DIM_BITS-1:0] pixel_address;
   vpp_flags_type flags;

   vpp_pixel_map #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_map (
      .clock(clock), .en(en), .quo_col(quo_col), .quo_row(quo_row),
      .status(status), .dim_w(dim_w), .dim_h(dim_h),
      .column(column), .row(row), .pixel_address(pixel_address), .flags(flags));

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = RSP_W'({pixel_address, row, column});
   assign rsp_tuser  = {flags.behind_camera, flags.on_screen};

   // A point behind the camera is never on screen.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(flags.on_screen && flags.behind_camera))
      else $error("on_screen and behind_camera both set");

   // Points not on screen carry zero position and address.
   a_off_screen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !flags.on_screen) |-> (column == '0 && row == '0
         && pixel_address == '0))
      else $error("off-screen result has nonzero fields");

   // An on-screen column lies inside the frame width.
   a_column_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && flags.on_screen) |-> ((DIM_W)'(column) < dim_w))
      else $error("on-screen column outside frame");

endmodule

// ===== verif/vertex_project_to_pixel_tb.sv =====
// Self-checking testbench for vertex_project_to_pixel: random and directed vertices
// under several transform and screen settings. Depends on vpp_pkg and the block's RTL.

module vertex_project_to_pixel_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vpp_pkg::*;

   // One expected pixel, with the fields laid out as the result port carries them.
   typedef struct {
      logic [11:0] column;
      logic [11:0] row;
      logic [23:0] pixel_address;
      logic        on_screen;
      logic        behind_camera;
   } pixel_type;

   // Projection scoreboard: it keeps its own copy of the registers, works out the pixel
   // for every accepted vertex and compares each result with the oldest pending pixel.
   class projection_scoreboard;
      logic [63:0] regs [8];
      pixel_type   pending [$];
      int          mismatches;
      int          results_seen;
      int          on_screen_seen;
      int          behind_seen;

      function new();
         regs[0] = 64'd65536;
         regs[1] = 64'd0;
         regs[2] = 64'd281474976710656;
         regs[3] = 64'd0;
         regs[4] = 64'd0;
         regs[5] = 64'd281474976710656;
         regs[6] = 64'd640;
         regs[7] = 64'd480;
      endfunction

      function void set_reg(int idx, logic [63:0] value);
         regs[idx] = (idx < 6) ? value : (value & 64'h1FFF);
      endfunction

      // Division rounded toward minus infinity; the divisor is always positive here.
      function longint floor_quot(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q -= 1;
         return q;
      endfunction

      function longint coef(logic [63:0] r, bit upper);
         return upper ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
      endfunction

      // One column of the transform: three floored products plus translation, saturated.
      function longint project_axis(int c, longint vx, longint vy, longint vz);
         longint s;
         longint lim;
         lim = longint'(1) <<< 47;
         s = ((vx * coef(regs[2*c], 0)) >>> 16) + ((vy * coef(regs[2*c], 1)) >>> 16)
           + ((vz * coef(regs[2*c+1], 0)) >>> 16) + coef(regs[2*c+1], 1);
         if (s < -lim) s = -lim;
         if (s > lim - 1) s = lim - 1;
         return s;
      endfunction

      function longint screen_dim(logic [63:0] r);
         longint d;
         d = longint'(r[12:0]);
         return (d > 4096) ? 4096 : d;
      endfunction

      function void note_vertex(logic [95:0] data);
         longint    vx, vy, vz, px, py, pw, w, h, c, r;
         pixel_type p;
         vx = longint'($signed(data[31:0]));
         vy = longint'($signed(data[63:32]));
         vz = longint'($signed(data[95:64]));
         px = project_axis(0, vx, vy, vz);
         py = project_axis(1, vx, vy, vz);
         pw = project_axis(2, vx, vy, vz);
         w = screen_dim(regs[6]);
         h = screen_dim(regs[7]);
         p = '{default: '0};
         if (pw <= 0) begin
            p.behind_camera = 1'b1;
         end else begin
            c = floor_quot(px * w, 2 * pw) + w / 2;
            r = floor_quot(-py * h, 2 * pw) + h / 2;
            if (c >= 0 && c < w && r >= 0 && r < h) begin
               p.on_screen = 1'b1;
               p.column = c[11:0];
               p.row = r[11:0];
               p.pixel_address = 24'(c + r * w);
            end
         end
         pending.push_back(p);
      endfunction

      function void report(string field, longint exp_v, longint act_v);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     results_seen, field, exp_v, act_v);
      endfunction

      function void check_pixel(logic [47:0] data, logic [1:0] user);
         pixel_type p;
         results_seen++;
         if (pending.size() == 0) begin
            report("unexpected result", 0, 1);
            return;
         end
         p = pending.pop_front();
         if (data[11:0] !== p.column) report("column", p.column, data[11:0]);
         if (data[23:12] !== p.row) report("row", p.row, data[23:12]);
         if (data[47:24] !== p.pixel_address)
            report("pixel_address", p.pixel_address, data[47:24]);
         if (user[0] !== p.on_screen) report("on_screen", p.on_screen, user[0]);
         if (user[1] !== p.behind_camera) report("behind_camera", p.behind_camera, user[1]);
         on_screen_seen += p.on_screen;
         behind_seen += p.behind_camera;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;    // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // column [11:0], row [23:12], pixel_address [47:24]
   logic [1:0]  rsp_tuser;    // on_screen [0], behind_camera [1]
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   projection_scoreboard sb;
   int hold_request;          // long receiver stall asked for by the stimulus
   int vertices_sent;
   int phases_run;

   vertex_project_to_pixel DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Handshakes are observed here, at the edge, with the values that were settled
   // before it, so the order of processes in the time step does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_vertex(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tuser);
      end
   end

   // The receiver switches at random among stall patterns: always ready, coin flip,
   // mostly stalled, or a fixed one-in-three rhythm. A long stall asked for by the
   // stimulus is counted down here while the sender keeps offering requests.
   initial begin
      int mode;
      int tick;
      int hold_left;
      mode = 0;
      tick = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 64 == 0) mode = $urandom_range(3);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(1));
               2: rsp_tready <= ($urandom_range(3) == 0);
               default: rsp_tready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   // Offer one request and return just after the edge that accepts it; the valid stays
   // high so that a following request can go out back to back.
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      bit taken;
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      vertices_sent++;
   endtask

   task automatic idle_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Wait until every pending pixel has come back, then let the pipeline run dry.
   task automatic drain();
      int guard;
      idle_sender(1);
      guard = 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
   endtask

   // Write all eight registers, one per cycle, while the block is idle.
   task automatic load_registers(logic [63:0] values [8]);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= values[i];
         @(posedge clock);
         sb.set_reg(i, values[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] jitter(int base, int spread);
      return 32'(base + $signed($urandom_range(2 * spread)) - spread);
   endfunction

   // Mostly vertices that land near the view volume with random detail, the rest noise.
   task automatic random_vertices(int count);
      int burst;
      int z;
      int span;
      logic [31:0] vx, vy, vz;
      while (count > 0) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && count > 0; k++) begin
            if ($urandom_range(9) < 7) begin
               z = $urandom_range(32768, 200 * 65536);
               span = z + z / 4;
               vx = 32'($signed($urandom_range(2 * span)) - span);
               vy = 32'($signed($urandom_range(2 * span)) - span);
               vz = ($urandom_range(15) == 0) ? -z : z;
            end else begin
               vx = $urandom;
               vy = $urandom;
               vz = $urandom;
            end
            send_vertex(vx, vy, vz);
            count--;
         end
         if ($urandom_range(3) != 0) idle_sender($urandom_range(1, 8));
      end
   endtask

   task automatic directed_vertices();
      logic [31:0] one;
      one = 32'h0001_0000;
      send_vertex(0, 0, one);                          // dead center
      send_vertex(0, 0, 0);                            // w exactly zero
      send_vertex(0, 0, -one);                         // w negative
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1);    // tiny positive w, far off screen
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, one);
      send_vertex(one, 0, one);                        // right edge, just off
      send_vertex(one - 1, 0, one);                    // right edge, just on
      send_vertex(-one, 0, one);                       // left edge
      send_vertex(0, one, one);                        // top row
      send_vertex(0, -one, one);                       // bottom edge, just off
      send_vertex(0, -one + 1, one);
      send_vertex(-1, -1, 32'hFFFF_FFFF);              // smallest negative w
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA);
   endtask

   task automatic identity_set(output logic [63:0] v [8], input int w, input int h);
      v[CSR_COEF_X_XY] = 64'd65536;
      v[CSR_COEF_X_ZT] = 64'd0;
      v[CSR_COEF_Y_XY] = 64'd65536 << 32;
      v[CSR_COEF_Y_ZT] = 64'd0;
      v[CSR_COEF_W_XY] = 64'd0;
      v[CSR_COEF_W_ZT] = 64'd65536;
      v[CSR_SCREEN_W] = 64'(w);
      v[CSR_SCREEN_H] = 64'(h);
   endtask

   // A transform near identity with random shear and translation.
   task automatic perturbed_set(output logic [63:0] v [8], input int w, input int h);
      v[CSR_COEF_X_XY] = {jitter(0, 8192), jitter(65536, 16384)};
      v[CSR_COEF_X_ZT] = {jitter(0, 131072), jitter(0, 8192)};
      v[CSR_COEF_Y_XY] = {jitter(65536, 16384), jitter(0, 8192)};
      v[CSR_COEF_Y_ZT] = {jitter(0, 131072), jitter(0, 8192)};
      v[CSR_COEF_W_XY] = {jitter(0, 2048), jitter(0, 2048)};
      v[CSR_COEF_W_ZT] = {jitter(0, 65536), jitter(65536, 16384)};
      v[CSR_SCREEN_W] = 64'(w);
      v[CSR_SCREEN_H] = 64'(h);
   endtask

   initial begin
      logic [63:0] setting [8];
      sb = new();
      hold_request = 0;
      vertices_sent = 0;
      phases_run = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values first, untouched, with the directed corner cases.
      directed_vertices();
      random_vertices(60);
      drain();
      phases_run++;

      // The identity transform with w = z written explicitly; a long receiver stall fills the pipe.
      identity_set(setting, 640, 480);
      load_registers(setting);
      hold_request = 300;
      random_vertices(110);
      drain();
      phases_run++;

      // Perturbed transform on a screen of random size.
      perturbed_set(setting, $urandom_range(2, 4096), $urandom_range(2, 4096));
      load_registers(setting);
      random_vertices(110);
      drain();
      phases_run++;

      // Smallest screen, then a zero-size one where nothing can be on screen.
      identity_set(setting, 1, 1);
      load_registers(setting);
      directed_vertices();
      random_vertices(60);
      drain();
      identity_set(setting, 0, 0);
      load_registers(setting);
      random_vertices(40);
      drain();
      phases_run += 2;

      // Largest screen, and values past the cap that must act as the cap.
      perturbed_set(setting, 4096, 4096);
      load_registers(setting);
      random_vertices(80);
      drain();
      identity_set(setting, 8191, 5000);
      setting[CSR_SCREEN_W] = 64'hFFFF_FFFF_FFFF_FFFF;
      load_registers(setting);
      directed_vertices();
      random_vertices(60);
      drain();
      phases_run += 2;

      // Extreme coefficients drive the column sums into saturation; fully random registers follow.
      for (int i = 0; i < 6; i++) setting[i] = (i % 2) ? 64'h8000_0000_8000_0000
                                                         : 64'h7FFF_FFFF_7FFF_FFFF;
      setting[CSR_SCREEN_W] = 64'd4096;
      setting[CSR_SCREEN_H] = 64'd1;
      load_registers(setting);
      directed_vertices();
      random_vertices(40);
      drain();
      for (int i = 0; i < 6; i++) setting[i] = {$urandom, $urandom};
      setting[CSR_SCREEN_W] = 64'($urandom_range(1, 4096));
      setting[CSR_SCREEN_H] = 64'($urandom);
      load_registers(setting);
      random_vertices(60);
      drain();
      phases_run += 2;

      // Back to a tilted transform on a common screen for the last stretch.
      perturbed_set(setting, 320, 200);
      load_registers(setting);
      random_vertices(80);
      drain();
      phases_run++;

      if (sb.pending.size() != 0) begin
         $display("%0d results never arrived", sb.pending.size());
         sb.mismatches += sb.pending.size();
      end
      $display("Sent %0d vertices over %0d register settings; %0d results checked,",
               vertices_sent, phases_run, sb.results_seen);
      $display("%0d on screen, %0d behind the camera, %0d mismatches.",
               sb.on_screen_seen, sb.behind_seen, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of the stimulus above.
   initial begin
      #5_000_000;
      $display("Timed out waiting for the block.");
      $display("FAIL");
      $finish;
   end

endmodule
